>>> rtl/uvs_pkg.sv
// Shared types and constants for the UV sphere triangle index generator.
package uvs_pkg;

  // Output corner width, fixed by the result item
  localparam int unsigned CORNER_BITS = 16;

  // Configuration port widths
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TESSELLATION = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_MODE   = 2'd1;

  // Reset value and lower clamp of the tessellation register
  localparam logic [CFG_DATA_BITS-1:0] TESS_RESET = 8'd16;
  localparam logic [CFG_DATA_BITS-1:0] TESS_MIN   = 8'd3;

  // Shape mode codes
  localparam logic MODE_SPHERE  = 1'b0;
  localparam logic MODE_CAPSULE = 1'b1;

  // Mesh section sequencer, one-hot
  typedef enum logic [2:0] {
    SEC_TOP    = 3'b001,
    SEC_BAND   = 3'b010,
    SEC_BOTTOM = 3'b100
  } section_t;

  // Effective mesh geometry derived from the configuration
  typedef struct packed {
    logic [8:0] slices;  // effective S, 3..256
    logic [8:0] rings;   // ring count R
  } geom_t;

  // One triangle
  typedef struct packed {
    logic [CORNER_BITS-1:0] corner_a;
    logic [CORNER_BITS-1:0] corner_b;
    logic [CORNER_BITS-1:0] corner_c;
    logic                   last_triangle;
  } tri_t;

endpackage

>>> rtl/uvs_seq.sv
// Mesh walk sequencer: section, band, slice and ring base counters plus corner arithmetic.
module uvs_seq #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  uvs_pkg::geom_t geom,
  input  logic          step,       // an item is accepted
  input  logic          restart,    // restart flag of that item
  input  logic          clear,      // configuration write restarts the walk
  output uvs_pkg::tri_t tri_o
);

  uvs_pkg::section_t       section_r, section_nxt;
  logic [7:0]              band_r, band_nxt;
  logic [7:0]              slice_r, slice_nxt;
  logic                    half_r, half_nxt;
  logic [INDEX_BITS-1:0]   base_r, base_nxt;

  // effective current state after a restart or an illegal section code
  uvs_pkg::section_t       cur_sec;
  logic [7:0]              cur_band;
  logic [7:0]              cur_slice;
  logic                    cur_half;
  logic [INDEX_BITS-1:0]   cur_base;
  logic                    sec_bad;

  logic [8:0]              slice_inc;
  logic [8:0]              band_inc;
  logic                    row_end;
  logic [7:0]              nx;
  logic [INDEX_BITS-1:0]   lower;
  logic [INDEX_BITS-1:0]   a_full, b_full, c_full;
  logic                    last;

  // detect a section code outside the three legal ones
  always_comb begin
    case (section_r)
      uvs_pkg::SEC_TOP, uvs_pkg::SEC_BAND, uvs_pkg::SEC_BOTTOM: sec_bad = 1'b0;
      default: sec_bad = 1'b1;
    endcase
  end

  // restart folds into the state used for this item
  always_comb begin
    if (restart || sec_bad) begin
      cur_sec   = uvs_pkg::SEC_TOP;
      cur_band  = 8'd1;
      cur_slice = 8'd0;
      cur_half  = 1'b0;
      cur_base  = INDEX_BITS'(1);
    end else begin
      cur_sec   = section_r;
      cur_band  = band_r;
      cur_slice = slice_r;
      cur_half  = half_r;
      cur_base  = base_r;
    end
  end

  // slice wrap and ring offsets
  assign slice_inc = {1'b0, cur_slice} + 9'd1;
  assign band_inc  = {1'b0, cur_band} + 9'd1;
  assign row_end   = (slice_inc >= geom.slices);
  assign nx        = row_end ? 8'd0 : slice_inc[7:0];
  assign lower     = cur_base + INDEX_BITS'(geom.slices);

  // corner indices
  always_comb begin
    a_full = cur_base + INDEX_BITS'(cur_slice);
    b_full = lower + INDEX_BITS'(cur_slice);
    c_full = lower + INDEX_BITS'(nx);
    last   = 1'b0;
    case (cur_sec)
      uvs_pkg::SEC_TOP: begin
        a_full = '0;
        b_full = INDEX_BITS'(1) + INDEX_BITS'(cur_slice);
        c_full = INDEX_BITS'(1) + INDEX_BITS'(nx);
      end
      uvs_pkg::SEC_BAND: begin
        if (cur_half) begin
          b_full = lower + INDEX_BITS'(nx);
          c_full = cur_base + INDEX_BITS'(nx);
        end
      end
      uvs_pkg::SEC_BOTTOM: begin
        b_full = lower;
        c_full = cur_base + INDEX_BITS'(nx);
        last   = row_end;
      end
      default: begin
        a_full = '0;
      end
    endcase
  end

  assign tri_o.corner_a      = a_full[uvs_pkg::CORNER_BITS-1:0];
  assign tri_o.corner_b      = b_full[uvs_pkg::CORNER_BITS-1:0];
  assign tri_o.corner_c      = c_full[uvs_pkg::CORNER_BITS-1:0];
  assign tri_o.last_triangle = last;

  // advance the walk
  always_comb begin
    section_nxt = cur_sec;
    band_nxt    = cur_band;
    slice_nxt   = cur_slice;
    half_nxt    = cur_half;
    base_nxt    = cur_base;
    case (cur_sec)
      uvs_pkg::SEC_TOP: begin
        if (row_end) begin
          section_nxt = uvs_pkg::SEC_BAND;
          band_nxt    = 8'd1;
          slice_nxt   = 8'd0;
          half_nxt    = 1'b0;
          base_nxt    = INDEX_BITS'(1);
        end else begin
          slice_nxt = slice_inc[7:0];
        end
      end
      uvs_pkg::SEC_BAND: begin
        if (!cur_half) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (row_end) begin
            slice_nxt = 8'd0;
            base_nxt  = lower;
            if (band_inc >= geom.rings) begin
              section_nxt = uvs_pkg::SEC_BOTTOM;
            end else begin
              band_nxt = band_inc[7:0];
            end
          end else begin
            slice_nxt = slice_inc[7:0];
          end
        end
      end
      uvs_pkg::SEC_BOTTOM: begin
        if (row_end) begin
          section_nxt = uvs_pkg::SEC_TOP;
          band_nxt    = 8'd1;
          slice_nxt   = 8'd0;
          half_nxt    = 1'b0;
          base_nxt    = INDEX_BITS'(1);
        end else begin
          slice_nxt = slice_inc[7:0];
        end
      end
      default: begin
        section_nxt = uvs_pkg::SEC_TOP;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      section_r <= uvs_pkg::SEC_TOP;
      band_r    <= 8'd1;
      slice_r   <= 8'd0;
      half_r    <= 1'b0;
      base_r    <= INDEX_BITS'(1);
    end else if (step) begin
      section_r <= section_nxt;
      band_r    <= band_nxt;
      slice_r   <= slice_nxt;
      half_r    <= half_nxt;
      base_r    <= base_nxt;
    end
  end

endmodule

>>> rtl/uvs_out_reg.sv
// Result register with valid/stall handshake towards the consumer.
module uvs_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,      // a new item's triangle is ready
  input  uvs_pkg::tri_t tri_i,
  output logic          busy,      // holds an item the consumer has not taken
  output logic          out_valid,
  input  logic          out_stall,
  output uvs_pkg::tri_t tri_o
);

  logic          valid_r;
  uvs_pkg::tri_t tri_r;

  // full and stalled: the producer must wait
  assign busy      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign tri_o     = tri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      tri_r <= tri_i;
    end
  end

endmodule

>>> rtl/uv_sphere_triangle_index_generator_unit.sv
// Top level of the UV sphere / capsule triangle index generator.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_restart
//  out_     output     out_valid/out_stall out_corner_a/b/c, out_last_triangle
//  cfg_     input      cfg_wr_en          cfg_index, cfg_data
//
// One triangle per accepted item, one item per cycle unless in_stall is high;
// out_valid rises the cycle after acceptance. Walk counters and corner logic
// sit between the state and result registers. Synchronous active-low
// reset gives tessellation 16, sphere mode and the first top-cap triangle.
// in_stall is high only while a result is held and out_stall is high.
module uv_sphere_triangle_index_generator_unit #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [uvs_pkg::CORNER_BITS-1:0]     out_corner_a,
  output logic [uvs_pkg::CORNER_BITS-1:0]     out_corner_b,
  output logic [uvs_pkg::CORNER_BITS-1:0]     out_corner_c,
  output logic                                out_last_triangle,
  input  logic                                cfg_wr_en,
  input  logic [uvs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [uvs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [uvs_pkg::CFG_DATA_BITS-1:0] tess_r;
  logic                              mode_r;
  logic                              cfg_hit;
  logic [uvs_pkg::CFG_DATA_BITS-1:0] tess_clamp;
  logic [8:0]                        slices;
  uvs_pkg::geom_t                    geom;
  logic                              in_acc;
  uvs_pkg::tri_t                     tri_calc;
  uvs_pkg::tri_t                     tri_out;

  // configuration registers
  assign cfg_hit = cfg_wr_en &&
                   (cfg_index == uvs_pkg::REG_TESSELLATION ||
                    cfg_index == uvs_pkg::REG_SHAPE_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tess_r <= uvs_pkg::TESS_RESET;
      mode_r <= uvs_pkg::MODE_SPHERE;
    end else if (cfg_wr_en) begin
      if (cfg_index == uvs_pkg::REG_TESSELLATION) begin
        tess_r <= cfg_data;
      end
      if (cfg_index == uvs_pkg::REG_SHAPE_MODE) begin
        mode_r <= cfg_data[0];
      end
    end
  end

  // effective slice count: clamp to 3, capsule rounds up to even
  assign tess_clamp = (tess_r < uvs_pkg::TESS_MIN) ? uvs_pkg::TESS_MIN : tess_r;
  assign slices     = {1'b0, tess_clamp} +
                      9'((mode_r == uvs_pkg::MODE_CAPSULE) && tess_clamp[0]);
  assign geom.slices = slices;
  assign geom.rings  = (mode_r == uvs_pkg::MODE_CAPSULE) ? slices : slices - 9'd1;

  // input handshake
  assign in_acc = in_valid && !in_stall;

  uvs_seq #(
    .INDEX_BITS (INDEX_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .step    (in_acc),
    .restart (in_restart),
    .clear   (cfg_hit),
    .tri_o   (tri_calc)
  );

  uvs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .tri_i     (tri_calc),
    .busy      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tri_o     (tri_out)
  );

  assign out_corner_a      = tri_out.corner_a;
  assign out_corner_b      = tri_out.corner_b;
  assign out_corner_c      = tri_out.corner_c;
  assign out_last_triangle = tri_out.last_triangle;

  // every accepted item shows up as a result in the next cycle
  a_acc_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted item produced no result");

  // the producer is held off only by a pending, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a pending result");

  // a restart always yields the first top-cap triangle
  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_restart) |=>
      (out_corner_a == '0 && out_corner_b == 16'd1 && out_corner_c == 16'd2 &&
       !out_last_triangle))
    else $error("restart did not give the first top-cap triangle");

endmodule
